[rtl/core/naf_pkg.sv]
// Shared types and constants of the neighbour average filter.
// Used by the controller, the datapath, the divider and the top level.
package naf_pkg;

  localparam int CFG_W   = 12;            // width of the size registers
  localparam int PIX_W   = 8;             // one colour channel
  localparam int ROW_W   = CFG_W + 1;     // row counter reaches height + 1
  localparam int SUM_W   = PIX_W + 3;     // sum of up to eight channel values
  localparam int CNT_W   = 4;             // neighbour count, 0 to 8
  localparam int DIV_C_W = 4;             // holds SUM_W iterations
  localparam int LANES   = 3;             // red, green, blue

  typedef logic [LANES*PIX_W-1:0] pixel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // take the input item and read both line stores
    logic shift;    // write line stores, shift window, advance position
    logic sum;      // add the neighbours and start the divider
    logic load;     // move the result into the output register
  } naf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emit;      // the item being shifted produces a result
    logic div_busy;  // divider still iterating
    logic out_busy;  // output register full and stalled
  } naf_status_t;

endpackage

[rtl/core/naf_div.sv]
// Three-lane restoring divider, one quotient bit per cycle in every lane.
// Depends on naf_pkg for the sum and count widths.
module naf_div
  import naf_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [LANES-1:0][SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]            divisor,
  output logic [LANES-1:0][SUM_W-1:0] quotient,
  output logic                        busy
);

  logic [LANES-1:0][CNT_W-1:0] rem;
  logic [LANES-1:0][CNT_W:0]   trial;
  logic [LANES-1:0]            fits;
  logic [CNT_W-1:0]            divisor_q;
  logic [DIV_C_W-1:0]          count;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      trial[k] = {rem[k], quotient[k][SUM_W-1]};
      fits[k]  = trial[k] >= {1'b0, divisor_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= DIV_C_W'(SUM_W);
    end else if (busy) begin
      busy  <= count != DIV_C_W'(1);
      count <= count - DIV_C_W'(1);
    end
  end

  // The quotient register starts out holding the dividend; its top bit is
  // shifted into the remainder while the new quotient bit enters below.
  always_ff @(posedge clk) begin
    if (start) begin
      divisor_q <= divisor;
      for (int k = 0; k < LANES; k++) begin
        rem[k]      <= '0;
        quotient[k] <= dividend[k];
      end
    end else if (busy) begin
      for (int k = 0; k < LANES; k++) begin
        if (fits[k]) begin
          rem[k] <= CNT_W'(trial[k] - {1'b0, divisor_q});
        end else begin
          rem[k] <= trial[k][CNT_W-1:0];
        end
        quotient[k] <= {quotient[k][SUM_W-2:0], fits[k]};
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> count != '0)
    else $error("divider busy with an exhausted count");

endmodule

[rtl/core/naf_datapath.sv]
// Datapath of the neighbour average filter: line stores, 3x3 window,
// raster position, neighbour sums, divider and output register.
// Depends on naf_pkg and instantiates naf_div.
module naf_datapath
  import naf_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic               clk,
  input  logic               rst,
  input  naf_cmd_t           cmd,
  output naf_status_t        status,
  input  logic [CFG_W-1:0]   cfg_width,
  input  logic [CFG_W-1:0]   cfg_height,
  input  logic               kind,
  input  logic [PIX_W-1:0]   red_in,
  input  logic [PIX_W-1:0]   green_in,
  input  logic [PIX_W-1:0]   blue_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PIX_W-1:0]   red_out,
  output logic [PIX_W-1:0]   green_out,
  output logic [PIX_W-1:0]   blue_out,
  output logic               frame_end
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  pixel_t line_upper  [MAX_WIDTH];
  pixel_t line_middle [MAX_WIDTH];

  pixel_t     window [3][3];
  pixel_t     up_rd, mid_rd, pix_q;
  logic [AW-1:0]    col_cnt, ci_q, ci_norm;
  logic [ROW_W-1:0] row_cnt, ri_q, ri_norm;
  logic [WW-1:0]    weff;
  logic [CFG_W-1:0] heff;
  logic [ROW_W-1:0] h_plus1;
  logic             restart;

  // Effective frame size: zero acts as one, the width saturates.
  always_comb begin
    if (cfg_width == '0) begin
      weff = WW'(1);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      weff = WW'(MAX_WIDTH);
    end else begin
      weff = WW'(cfg_width);
    end
    heff    = (cfg_height == '0) ? CFG_W'(1) : cfg_height;
    h_plus1 = ROW_W'(heff) + ROW_W'(1);
    // A position beyond the frame that the registers now describe restarts it.
    restart = (WW'(col_cnt) >= weff) || (row_cnt > h_plus1) ||
              ((row_cnt == h_plus1) && (col_cnt != '0));
    ci_norm = restart ? '0 : col_cnt;
    ri_norm = restart ? '0 : row_cnt;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ci_q   <= ci_norm;
      ri_q   <= ri_norm;
      pix_q  <= kind ? '0 : {red_in, green_in, blue_in};
      up_rd  <= line_upper[ci_norm];
      mid_rd <= line_middle[ci_norm];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      line_upper[ci_q]  <= mid_rd;
      line_middle[ci_q] <= pix_q;
    end
  end

  // Centre position of the item being shifted and its in-image neighbours.
  logic                    ci_zero, last;
  logic [ROW_W:0]          cr_u;
  logic signed [ROW_W:0]   cr, hs;
  logic [WW-1:0]           cc, col_inc;
  logic [2:0]              row_ok, col_ok, row_ok_q, col_ok_q;
  logic [AW-1:0]           col_next;
  logic [ROW_W-1:0]        row_next;
  logic                    last_q;

  always_comb begin
    ci_zero = ci_q == '0;
    cr_u    = {1'b0, ri_q} - (ci_zero ? (ROW_W+1)'(2) : (ROW_W+1)'(1));
    cr      = signed'(cr_u);
    hs      = signed'((ROW_W+1)'(heff));
    row_ok[0] = (cr > 0) && (cr <= hs);
    row_ok[1] = (cr >= 0) && (cr < hs);
    row_ok[2] = (cr >= -1) && (cr < hs - 1);
    cc        = ci_zero ? weff - WW'(1) : WW'(ci_q) - WW'(1);
    col_ok[0] = cc != '0;
    col_ok[1] = 1'b1;
    col_ok[2] = cc != weff - WW'(1);
    last      = (ri_q == h_plus1) && ci_zero;
    col_inc   = WW'(ci_q) + WW'(1);
    if (last) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= weff) begin
      col_next = '0;
      row_next = ri_q + ROW_W'(1);
    end else begin
      col_next = AW'(col_inc);
      row_next = ri_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          window[r][c] <= '0;
        end
      end
    end else if (cmd.shift) begin
      col_cnt <= col_next;
      row_cnt <= row_next;
      for (int r = 0; r < 3; r++) begin
        window[r][0] <= window[r][1];
        window[r][1] <= window[r][2];
      end
      window[0][2] <= up_rd;
      window[1][2] <= mid_rd;
      window[2][2] <= pix_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      row_ok_q <= row_ok;
      col_ok_q <= col_ok;
      last_q   <= last;
    end
  end

  // Neighbour sums, centre left out.
  logic [LANES-1:0][SUM_W-1:0] sums;
  logic [CNT_W-1:0]            n_sum, n_q;
  pixel_t                      centre_q;

  always_comb begin
    sums  = '0;
    n_sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!(r == 1 && c == 1) && row_ok_q[r] && col_ok_q[c]) begin
          for (int k = 0; k < LANES; k++) begin
            sums[k] = sums[k] + SUM_W'(window[r][c][(LANES-1-k)*PIX_W +: PIX_W]);
          end
          n_sum = n_sum + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      n_q      <= n_sum;
      centre_q <= window[1][1];
    end
  end

  logic [LANES-1:0][SUM_W-1:0] quot;
  logic                        div_busy;

  naf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sum),
    .dividend (sums),
    .divisor  (n_sum),
    .quotient (quot),
    .busy     (div_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // With no in-image neighbour the centre passes through unchanged.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_end <= last_q;
      if (n_q == '0) begin
        red_out   <= centre_q[2*PIX_W +: PIX_W];
        green_out <= centre_q[PIX_W +: PIX_W];
        blue_out  <= centre_q[0 +: PIX_W];
      end else begin
        red_out   <= quot[0][PIX_W-1:0];
        green_out <= quot[1][PIX_W-1:0];
        blue_out  <= quot[2][PIX_W-1:0];
      end
    end
  end

  assign status.emit     = row_ok[1];
  assign status.div_busy = div_busy;
  assign status.out_busy = out_valid && out_stall;

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(out_valid && out_stall))
    else $error("output register overwritten while stalled");
  a_emit_row: assert property (@(posedge clk) disable iff (rst)
    (cmd.shift && row_ok[1]) |-> ri_q != '0)
    else $error("result emitted during the first row");

endmodule

[rtl/core/naf_ctrl.sv]
// Controller of the neighbour average filter: sequences accept, shift,
// sum, divide and load. Depends on naf_pkg for the command and status types.
module naf_ctrl
  import naf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output naf_cmd_t    cmd,
  input  naf_status_t status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SUM,
    ST_DIV,
    ST_LOAD
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = status.emit ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!status.div_busy) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // Wait here until the previous result has left the output register.
        cmd.load = !status.out_busy;
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= state_next != ST_IDLE;
    end
  end

  a_stall_idle: assert property (@(posedge clk) disable iff (rst)
    in_stall == (state != ST_IDLE))
    else $error("input stall out of step with the controller state");
  a_sum_free: assert property (@(posedge clk) disable iff (rst)
    cmd.sum |-> !status.div_busy)
    else $error("sum issued while the divider is busy");

endmodule

[rtl/core/neighbour_average_filter_unit.sv]
// Top level of the neighbour average filter: configuration registers on an
// APB-style port, controller and datapath. Depends on naf_pkg, naf_ctrl
// and naf_datapath.
//
// Input channel: in_valid / in_stall carry kind and the RGB pixel in raster
// order; a transfer happens at an edge with in_valid high and in_stall low.
// Each frame is W*H pixels followed by W+1 pad items (kind = 1).
// Output channel: out_valid / out_stall carry the neighbour mean of the
// centre pixel one row and one column behind the input, with frame_end on
// the last pixel of the frame.
// Steps: an item that gives no result (the warm-up of each frame) is
// accepted and shifted into the window. An item that gives a result goes
// on to the neighbour sum, the divider, which finds one quotient bit per
// cycle, and the load of the output register.
// The result sits in an output register, so the next item is taken while
// it waits; if the receiver still stalls when the following result is
// ready, the block holds that result and stops taking input.
// Reset clears the position counters, the window and the output valid flag
// and sets the size to 640 x 480. The line stores are not cleared; entries
// not yet written only feed rows above the image, which are never used.
// Size registers: image_width at address 0, image_height at address 4.
module neighbour_average_filter_unit
  import naf_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             kind,
  input  logic [PIX_W-1:0] red_in,
  input  logic [PIX_W-1:0] green_in,
  input  logic [PIX_W-1:0] blue_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] red_out,
  output logic [PIX_W-1:0] green_out,
  output logic [PIX_W-1:0] blue_out,
  output logic             frame_end,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  logic [CFG_W-1:0] image_width, image_height;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_WIDTH:  image_width  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: image_height <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      default:    prdata = '0;
    endcase
  end

  naf_cmd_t    cmd;
  naf_status_t status;

  naf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  naf_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_width  (image_width),
    .cfg_height (image_height),
    .kind       (kind),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .frame_end  (frame_end)
  );

endmodule

[dv/neighbour_average_filter_unit_test.sv]
// Self-checking testbench for neighbour_average_filter_unit: random items, directed rows and random frames.
// A built-in predictor of the 3x3 neighbour mean works out the expected results; some directed rows type theirs.
// Depends on naf_pkg and the RTL of the filter.
`timescale 1ns / 100ps

module neighbour_average_filter_unit_test
  import naf_pkg::*;
();

  localparam int MAX_W = 2048;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [2:0] ADDR_IMAGE_WIDTH = 3'd0;
  localparam logic [2:0] ADDR_IMAGE_HEIGHT = 3'd4;
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_PAD = 1'b1;
  localparam logic [31:0] RESET_WIDTH = 32'd640;
  localparam logic [31:0] RESET_HEIGHT = 32'd480;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
  } mean_t;

  typedef enum logic [1:0] {ROW_WIDTH, ROW_HEIGHT, ROW_ITEM} row_op_e;
  typedef enum logic [1:0] {OUT_NONE, OUT_TYPED, OUT_PREDICTED} row_chk_e;

  typedef struct {
    row_op_e     op;
    logic [31:0] value;
    logic        kind;
    pixel_t      px;
    row_chk_e    chk;
    mean_t       result;
  } drill_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [PIX_W-1:0] red_in = '0;
  logic [PIX_W-1:0] green_in = '0;
  logic [PIX_W-1:0] blue_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;
  logic frame_end;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  neighbour_average_filter_unit #(.MAX_WIDTH(MAX_W)) dut (.*);

  always #6 clk = ~clk;

  // Predictor state: size registers, the two stored rows, the 3x3 window and
  // the position of the next item in the frame stream.
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  pixel_t upper_row [MAX_W];
  pixel_t middle_row [MAX_W];
  pixel_t window_px [0:2][0:2];
  int unsigned col_pos;
  int unsigned row_pos;

  mean_t pending_means[$];
  drill_row_t directed_rows[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int frame_ends = 0;
  int cycle_count = 0;

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return 32'(width_reg);
  endfunction

  function automatic int unsigned active_height();
    return (height_reg == 0) ? 1 : 32'(height_reg);
  endfunction

  // True when the next item lands on an image pixel rather than a pad slot.
  function automatic bit at_pixel_position();
    int unsigned w, h, c, r;
    w = active_width();
    h = active_height();
    c = col_pos;
    r = row_pos;
    if (c >= w || r > h + 1 || (r == h + 1 && c != 0)) begin
      c = 0;
      r = 0;
    end
    return r < h;
  endfunction

  // Advances the predictor by one item; returns 1 when the item yields a mean.
  function automatic bit neighbour_mean(input logic k, input pixel_t px, output mean_t res);
    int unsigned w, h, ci, ri, n, sum_r, sum_g, sum_b;
    int cr, cc, yr, xc, dr, dc, i;
    pixel_t pix, up, mid, nb;
    bit last;
    w = active_width();
    h = active_height();
    res = '0;
    // A resize can leave the position outside the new frame; it then restarts.
    if (col_pos >= w || row_pos > h + 1 || (row_pos == h + 1 && col_pos != 0)) begin
      col_pos = 0;
      row_pos = 0;
    end
    ci = col_pos;
    ri = row_pos;
    pix = (k == KIND_PAD) ? '0 : px;
    up = upper_row[ci];
    mid = middle_row[ci];
    upper_row[ci] = mid;
    middle_row[ci] = pix;
    for (i = 0; i < 3; i++) begin
      window_px[i][0] = window_px[i][1];
      window_px[i][1] = window_px[i][2];
    end
    window_px[0][2] = up;
    window_px[1][2] = mid;
    window_px[2][2] = pix;
    if (ci > 0) begin
      cr = int'(ri) - 1;
      cc = int'(ci) - 1;
    end else begin
      cr = int'(ri) - 2;
      cc = int'(w) - 1;
    end
    last = (ri == h + 1 && ci == 0);
    col_pos = ci + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = ri + 1;
    end
    if (last) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (cr < 0 || cr >= int'(h)) return 0;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    n = 0;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        yr = cr + dr;
        xc = cc + dc;
        if (!(dr == 0 && dc == 0) && yr >= 0 && yr < int'(h) && xc >= 0 && xc < int'(w)) begin
          nb = window_px[dr + 1][dc + 1];
          sum_r += nb[23:16];
          sum_g += nb[15:8];
          sum_b += nb[7:0];
          n++;
        end
      end
    end
    if (n != 0) begin
      res.red = 8'(sum_r / n);
      res.green = 8'(sum_g / n);
      res.blue = 8'(sum_b / n);
    end else begin
      // No neighbour inside the image: the centre goes through unchanged.
      {res.red, res.green, res.blue} = window_px[1][1];
    end
    res.frame_end = last;
    return 1;
  endfunction

  function automatic logic [7:0] channel_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return 8'h00;
    if (pick < 30) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic void plan(input row_op_e op, input logic [31:0] value, input logic k,
                               input pixel_t px, input row_chk_e chk, input mean_t res);
    directed_rows.push_back('{op, value, k, px, chk, res});
  endfunction

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_size_reg(input logic [2:0] addr, input logic [31:0] want);
    logic [31:0] got;
    apb_access(1'b0, addr, '0, got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("register at address %0d reads %0d, expected %0d", addr, got, want);
    end
  endtask

  // Lowers valid and holds off until every expected mean has come back, plus
  // time for a warm-up item that is still inside the block.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] unused;
    wait_drained();
    apb_access(1'b1, addr, value, unused);
    if (addr == ADDR_IMAGE_WIDTH) width_reg = value[CFG_W-1:0];
    else height_reg = value[CFG_W-1:0];
    check_size_reg(addr, value & 32'hFFF);
  endtask

  task automatic push_item(input logic k, input pixel_t px, input row_chk_e chk,
                           input mean_t typed);
    mean_t predicted;
    bit has_mean;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    kind <= k;
    {red_in, green_in, blue_in} <= px;
    do @(posedge clk); while (in_stall);
    items_sent++;
    has_mean = neighbour_mean(k, px, predicted);
    if (chk == OUT_PREDICTED && has_mean) pending_means.push_back(predicted);
    else if (chk == OUT_TYPED) pending_means.push_back(typed);
  endtask

  // Kinds follow the frame position, with a share of them flipped as noise.
  task automatic stream_items(input int count, input int noise_pct, input int hold_at);
    int n;
    logic k;
    for (n = 0; n < count; n++) begin
      if (n == hold_at) wait_drained();
      k = at_pixel_position() ? KIND_PIXEL : KIND_PAD;
      if ($urandom_range(99) < noise_pct) k = ~k;
      push_item(k, {channel_value(), channel_value(), channel_value()}, OUT_PREDICTED, '0);
    end
  endtask

  task automatic random_phase(input int budget);
    logic [31:0] w_val, h_val;
    int sel;
    case ($urandom_range(9))
      0: w_val = $urandom_range(9, 64);
      1: w_val = 0;
      default: w_val = $urandom_range(1, 8);
    endcase
    case ($urandom_range(9))
      0: h_val = $urandom_range(7, 16);
      1: h_val = 0;
      default: h_val = $urandom_range(1, 6);
    endcase
    // Changing only one register often leaves the position mid-frame.
    sel = $urandom_range(3);
    if (sel != 1) set_size(ADDR_IMAGE_WIDTH, w_val);
    if (sel != 2) set_size(ADDR_IMAGE_HEIGHT, h_val);
    stream_items(budget, ($urandom_range(4) == 0) ? 40 : 5, $urandom_range(budget - 1));
  endtask

  always @(posedge clk) begin : result_side
    mean_t got, want;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      got = {red_out, green_out, blue_out, frame_end};
      if (pending_means.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected transfer: r=%0d g=%0d b=%0d frame_end=%0b",
                   got.red, got.green, got.blue, got.frame_end);
      end else begin
        want = pending_means.pop_front();
        results_seen++;
        if (got.frame_end === 1'b1) frame_ends++;
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.frame_end !== want.frame_end) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
                     want.red, want.green, want.blue, want.frame_end,
                     got.red, got.green, got.blue, got.frame_end);
        end
      end
    end
    out_stall <= !rst && ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("neighbour_average_filter_unit_test failed");
    $finish;
  end

  initial begin
    int i, p;
    width_reg = RESET_WIDTH[CFG_W-1:0];
    height_reg = RESET_HEIGHT[CFG_W-1:0];
    for (i = 0; i < MAX_W; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    for (i = 0; i < 9; i++) window_px[i / 3][i % 3] = '0;
    col_pos = 0;
    row_pos = 0;

    // A 1x1 image through a zero width: the centre passes through.
    plan(ROW_WIDTH, 0, KIND_PIXEL, '0, OUT_NONE, '0);
    plan(ROW_HEIGHT, 1, KIND_PIXEL, '0, OUT_NONE, '0);
    plan(ROW_ITEM, 0, KIND_PIXEL, {8'd255, 8'd0, 8'd170}, OUT_NONE, '0);
    plan(ROW_ITEM, 0, KIND_PAD, {8'd9, 8'd9, 8'd9}, OUT_NONE, '0);
    plan(ROW_ITEM, 0, KIND_PAD, {8'd0, 8'd0, 8'd0}, OUT_TYPED,
         {8'd255, 8'd0, 8'd170, 1'b1});
    // A pad in the pixel slot reads as black; pixel data in pad slots is dropped.
    plan(ROW_ITEM, 0, KIND_PAD, {8'd12, 8'd34, 8'd56}, OUT_NONE, '0);
    plan(ROW_ITEM, 0, KIND_PIXEL, {8'd255, 8'd255, 8'd255}, OUT_NONE, '0);
    plan(ROW_ITEM, 0, KIND_PIXEL, {8'd255, 8'd255, 8'd255}, OUT_TYPED,
         {8'd0, 8'd0, 8'd0, 1'b1});
    // Two pixels side by side: each one's mean is the other pixel.
    plan(ROW_WIDTH, 2, KIND_PIXEL, '0, OUT_NONE, '0);
    plan(ROW_ITEM, 0, KIND_PIXEL, {8'd255, 8'd255, 8'd255}, OUT_NONE, '0);
    plan(ROW_ITEM, 0, KIND_PIXEL, {8'd0, 8'd0, 8'd0}, OUT_NONE, '0);
    plan(ROW_ITEM, 0, KIND_PAD, {8'd7, 8'd7, 8'd7}, OUT_NONE, '0);
    plan(ROW_ITEM, 0, KIND_PAD, {8'd0, 8'd0, 8'd0}, OUT_TYPED, {8'd0, 8'd0, 8'd0, 1'b0});
    plan(ROW_ITEM, 0, KIND_PAD, {8'd0, 8'd0, 8'd0}, OUT_TYPED,
         {8'd255, 8'd255, 8'd255, 1'b1});
    // A 3x3 image: the middle pixel takes eight neighbours, corners three.
    plan(ROW_WIDTH, 3, KIND_PIXEL, '0, OUT_NONE, '0);
    plan(ROW_HEIGHT, 3, KIND_PIXEL, '0, OUT_NONE, '0);
    plan(ROW_ITEM, 0, KIND_PIXEL, {8'd200, 8'd10, 8'd255}, OUT_PREDICTED, '0);
    plan(ROW_ITEM, 0, KIND_PIXEL, {8'd0, 8'd255, 8'd1}, OUT_PREDICTED, '0);
    plan(ROW_ITEM, 0, KIND_PIXEL, {8'd17, 8'd33, 8'd250}, OUT_PREDICTED, '0);
    plan(ROW_ITEM, 0, KIND_PIXEL, {8'd255, 8'd255, 8'd255}, OUT_PREDICTED, '0);
    plan(ROW_ITEM, 0, KIND_PIXEL, {8'd128, 8'd64, 8'd32}, OUT_PREDICTED, '0);
    plan(ROW_ITEM, 0, KIND_PIXEL, {8'd0, 8'd0, 8'd0}, OUT_PREDICTED, '0);
    plan(ROW_ITEM, 0, KIND_PIXEL, {8'd1, 8'd2, 8'd3}, OUT_PREDICTED, '0);
    plan(ROW_ITEM, 0, KIND_PIXEL, {8'd250, 8'd128, 8'd99}, OUT_PREDICTED, '0);
    plan(ROW_ITEM, 0, KIND_PIXEL, {8'd255, 8'd0, 8'd77}, OUT_PREDICTED, '0);
    for (i = 0; i < 4; i++)
      plan(ROW_ITEM, 0, KIND_PAD, {8'd255, 8'd255, 8'd255}, OUT_PREDICTED, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    check_size_reg(ADDR_IMAGE_WIDTH, RESET_WIDTH);
    check_size_reg(ADDR_IMAGE_HEIGHT, RESET_HEIGHT);

    send_idle_pct = 16;
    recv_idle_pct = 70;
    // An oversized width saturates and a zero height acts as one. The start of
    // that first row gives no result, and the next resize abandons the frame.
    set_size(ADDR_IMAGE_WIDTH, 4095);
    set_size(ADDR_IMAGE_HEIGHT, 0);
    stream_items(40, 0, -1);

    foreach (directed_rows[row]) begin
      case (directed_rows[row].op)
        ROW_WIDTH: set_size(ADDR_IMAGE_WIDTH, directed_rows[row].value);
        ROW_HEIGHT: set_size(ADDR_IMAGE_HEIGHT, directed_rows[row].value);
        default: push_item(directed_rows[row].kind, directed_rows[row].px,
                           directed_rows[row].chk, directed_rows[row].result);
      endcase
    end

    for (p = 0; p < 15; p++) begin
      if (p == 5) begin
        send_idle_pct = 70;
        recv_idle_pct = 16;
        // Tallest frame, one column wide; the next resize cuts it short.
        set_size(ADDR_IMAGE_WIDTH, 1);
        set_size(ADDR_IMAGE_HEIGHT, 2048);
        stream_items(120, 0, -1);
      end
      if (p == 10) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_phase($urandom_range(40, 90));
    end

    wait_drained();
    $display("covered %0d input transfers and %0d results with %0d frame ends",
             items_sent, results_seen, frame_ends);
    $display("sizes from 1x1 to an oversized width and 2048 rows, noisy kinds and mid-frame resizes");
    if (fail_count == 0 && pending_means.size() == 0) begin
      $display("neighbour_average_filter_unit_test passed");
    end else begin
      $display("neighbour_average_filter_unit_test failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/naf_pkg.sv
rtl/core/naf_div.sv
rtl/core/naf_datapath.sv
rtl/core/naf_ctrl.sv
rtl/core/neighbour_average_filter_unit.sv
dv/neighbour_average_filter_unit_test.sv
